FILE: design/kli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_pkg: keyframe interpolator shared types and constants
// Sequencer states, register indexes, function codes, fixed widths and divider types.
// ----------------------------------------------------------------------------
package kli_pkg;

   localparam int unsigned ONE_Q16 = 65536;
   localparam int unsigned PHASE_W = 17;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned TIME_W  = 32;

   localparam logic [1:0] REG_START = 2'd0;
   localparam logic [1:0] REG_RUN   = 2'd1;
   localparam logic [1:0] REG_LOOP  = 2'd2;
   localparam logic [1:0] REG_COUNT = 2'd3;

   localparam logic FN_WRITE = 1'b0;
   localparam logic FN_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_PDIV,
      ST_SCAN_RD,
      ST_SCAN,
      ST_RD_B1,
      ST_MUL,
      ST_IDIV,
      ST_END_RD,
      ST_END,
      ST_DONE
   } state_type;

   // control from the sequencer to the divider
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [32:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
      logic [32:0] remainder;
   } div_stat_type;

endpackage

FILE: design/keyframe_linear_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_top: piecewise linear keyframe interpolator
// Keyframe table in a synchronous memory, shared iterative divider.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// req      in   tdata: func, key_index, key_phase, key_value, query_time
// rsp      out  tdata: ok, result_value, at_end
// csr      in   APB: start_time, run_length, loop_enable, key_count
//
// A keyframe write passes through the done state before the next transaction is accepted.
// A query runs up to two divider passes (modulo, phase), a scan of one
// memory read per key, then at most one divider pass for the interpolation
// quotient.
// Reset is synchronous and clears the key table through valid bits.
// A result waits in the output register; the next one waits in the done
// state, and the input is held until the sequencer is idle again.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_top #(
   parameter int unsigned MAX_KEYS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[0], key_index[4:1], key_phase[21:5], key_value[53:22], query_time[85:54]
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ok[0], result_value[32:1], at_end[33]
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int unsigned CW = $clog2(MAX_KEYS + 1);

   // configuration
   logic [31:0] start_ff;
   logic [31:0] run_ff;
   logic        loop_ff;
   logic [4:0]  kcnt_ff;
   logic        cwr;
   logic [1:0]  creg;

   assign csr_pready = 1'b1;
   assign cwr  = csr_psel & csr_penable & csr_pwrite;
   assign creg = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         run_ff   <= '0;
         loop_ff  <= 1'b1;
         kcnt_ff  <= '0;
      end else if (cwr) begin
         case (creg)
            kli_pkg::REG_START: start_ff <= csr_pwdata;
            kli_pkg::REG_RUN:   run_ff   <= csr_pwdata;
            kli_pkg::REG_LOOP:  loop_ff  <= csr_pwdata[0];
            kli_pkg::REG_COUNT: kcnt_ff  <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (creg)
         kli_pkg::REG_START: csr_prdata = start_ff;
         kli_pkg::REG_RUN:   csr_prdata = run_ff;
         kli_pkg::REG_LOOP:  csr_prdata = {31'd0, loop_ff};
         kli_pkg::REG_COUNT: csr_prdata = {27'd0, kcnt_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // effective key count
   logic [CW-1:0] n_cnt;
   always_comb begin
      if ({27'd0, kcnt_ff} > 32'(MAX_KEYS)) n_cnt = CW'(MAX_KEYS);
      else                                    n_cnt = CW'(kcnt_ff);
   end

   // input fields
   logic        f_func;
   logic [3:0]  f_idx;
   logic [16:0] f_kph;
   logic [31:0] f_kval;
   logic [31:0] f_time;
   assign f_func = req_tdata[0];
   assign f_idx  = req_tdata[4:1];
   assign f_kph  = req_tdata[21:5];
   assign f_kval = req_tdata[53:22];
   assign f_time = req_tdata[85:54];

   kli_pkg::state_type st_ff, st_in;
   logic          after_ff, after_in;   // time > start
   logic [16:0]   ph_ff, ph_in;
   logic [CW-1:0] i_ff, i_in;
   logic [16:0]   kb_ff, kb_in;
   logic [31:0]   vb_ff, vb_in;
   logic          neg_ff, neg_in;
   logic [63:0]   prod_ff, prod_in;
   logic          ok_ff, ok_in;
   logic          end_ff, end_in;
   logic [31:0]   val_ff, val_in;
   logic          ov_ff, ov_in;
   // divisor for interpolation captured in the scan step
   logic [16:0]   dk_ff, dk_in;

   logic [AW-1:0] rd_addr;
   logic [16:0]   rd_phase;
   logic [31:0]   rd_value;
   logic          wr_en;
   logic          acc;

   kli_pkg::div_cmd_type  dcmd;
   kli_pkg::div_stat_type dstat;

   kli_mem #(.DEPTH(MAX_KEYS), .AW(AW)) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (AW'(f_idx)),
      .wr_phase (f_kph),
      .wr_value (f_kval),
      .rd_addr  (rd_addr),
      .rd_phase (rd_phase),
      .rd_value (rd_value)
   );

   kli_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .stat  (dstat)
   );

   assign req_tready = (st_ff == kli_pkg::ST_IDLE);
   assign acc = req_tvalid & req_tready;
   assign wr_en = acc && (f_func == kli_pkg::FN_WRITE) && ({28'd0, f_idx} < 32'(n_cnt));

   // next state and datapath
   logic [31:0] end_time;
   logic [17:0] off;
   logic [17:0] dk;
   logic signed [32:0] dv;
   logic signed [51:0] pr;
   logic [31:0] qv;
   assign end_time = start_ff + run_ff;
   assign off = {1'b0, ph_ff} - {1'b0, kb_ff};
   assign dk  = {1'b0, rd_phase} - {1'b0, kb_ff};
   assign dv  = {rd_value[31], rd_value} - {vb_ff[31], vb_ff};
   assign pr  = dv * $signed({1'b0, off});

   always_comb begin
      st_in    = st_ff;
      after_in = after_ff;
      ph_in    = ph_ff;
      i_in     = i_ff;
      kb_in    = kb_ff;
      vb_in    = vb_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      ok_in    = ok_ff;
      end_in   = end_ff;
      val_in   = val_ff;
      ov_in    = ov_ff;
      rd_addr  = i_ff[AW-1:0];
      dcmd     = '0;
      qv       = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (st_ff)
         kli_pkg::ST_IDLE: begin
            if (acc) begin
               ok_in  = 1'b0;
               end_in = 1'b0;
               val_in = '0;
               after_in = f_time > start_ff;
               if (f_func == kli_pkg::FN_WRITE) begin
                  ok_in = wr_en;
                  st_in = kli_pkg::ST_DONE;
               end else if (n_cnt == '0) begin
                  st_in = kli_pkg::ST_DONE;
               end else if (!loop_ff && f_time < start_ff) begin
                  ok_in = 1'b1; end_in = 1'b1;
                  i_in = '0;
                  st_in = kli_pkg::ST_END_RD;
               end else if (!loop_ff && f_time > end_time) begin
                  ok_in = 1'b1; end_in = 1'b1;
                  i_in = n_cnt - CW'(1);
                  st_in = kli_pkg::ST_END_RD;
               end else if (run_ff == '0) begin
                  ok_in = 1'b1;
                  ph_in = 17'(kli_pkg::ONE_Q16);
                  i_in  = '0;
                  st_in = kli_pkg::ST_SCAN_RD;
               end else begin
                  ok_in = 1'b1;
                  dcmd.start    = 1'b1;
                  dcmd.dividend = {32'd0, (f_time > start_ff) ? f_time - start_ff
                                                              : start_ff - f_time};
                  dcmd.divisor  = {1'b0, run_ff};
                  st_in = kli_pkg::ST_MOD;
               end
            end
         end
         kli_pkg::ST_MOD: begin
            if (dstat.done) begin
               dcmd.start    = 1'b1;
               dcmd.dividend = {15'd0, dstat.remainder[31:0], 17'd0} >> 1;
               dcmd.divisor  = {1'b0, run_ff};
               st_in = kli_pkg::ST_PDIV;
            end
         end
         kli_pkg::ST_PDIV: begin
            if (dstat.done) begin
               if (after_ff) ph_in = dstat.quotient[16:0];
               else ph_in = 17'(kli_pkg::ONE_Q16) - dstat.quotient[16:0];
               i_in  = '0;
               st_in = kli_pkg::ST_SCAN_RD;
            end
         end
         kli_pkg::ST_SCAN_RD: begin
            // read issued for entry i
            st_in = kli_pkg::ST_SCAN;
         end
         kli_pkg::ST_SCAN: begin
            if (i_ff == '0 && ph_ff < rd_phase) begin
               val_in = rd_value;
               st_in  = kli_pkg::ST_DONE;
            end else if (rd_phase <= ph_ff) begin
               kb_in = rd_phase;
               vb_in = rd_value;
               if (i_ff + CW'(1) >= n_cnt) begin
                  val_in = rd_value;
                  st_in  = kli_pkg::ST_DONE;
               end else begin
                  i_in    = i_ff + CW'(1);
                  rd_addr = AW'(i_ff + CW'(1));
                  st_in   = kli_pkg::ST_SCAN;
               end
            end else begin
               // rd holds entry b+1, strictly above the phase
               prod_in = 64'(pr);
               neg_in  = pr[51];
               st_in   = kli_pkg::ST_MUL;
            end
         end
         kli_pkg::ST_MUL: begin
            dcmd.start    = 1'b1;
            dcmd.dividend = neg_ff ? 64'(-prod_ff) : prod_ff;
            dcmd.divisor  = 33'(dk_ff);
            st_in = kli_pkg::ST_IDIV;
         end
         kli_pkg::ST_IDIV: begin
            if (dstat.done) begin
               qv = neg_ff ? 32'(-dstat.quotient) : dstat.quotient[31:0];
               val_in = vb_ff + qv;
               st_in = kli_pkg::ST_DONE;
            end
         end
         kli_pkg::ST_END_RD: begin
            st_in = kli_pkg::ST_END;
         end
         kli_pkg::ST_END: begin
            val_in = rd_value;
            st_in  = kli_pkg::ST_DONE;
         end
         kli_pkg::ST_DONE: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               st_in = kli_pkg::ST_IDLE;
            end
         end
         default: st_in = kli_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      dk_in = dk_ff;
      if (st_ff == kli_pkg::ST_SCAN) dk_in = dk[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= kli_pkg::ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
      after_ff <= after_in;
      ph_ff    <= ph_in;
      i_ff     <= i_in;
      kb_ff    <= kb_in;
      vb_ff    <= vb_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      ok_ff    <= ok_in;
      end_ff   <= end_in;
      val_ff   <= val_in;
      dk_ff    <= dk_in;
   end

   // output register loaded when a result is complete
   logic [33:0] out_ff;
   always_ff @(posedge clock) begin
      if (st_ff == kli_pkg::ST_DONE && (!ov_ff || rsp_tready))
         out_ff <= {end_ff, ok_ff ? val_ff : 32'd0, ok_ff};
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {6'd0, out_ff};

   ast_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (st_ff == kli_pkg::ST_IDLE) |-> !dstat.busy)
      else $error("divider busy while idle");

   ast_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      acc |=> (st_ff != kli_pkg::ST_IDLE))
      else $error("accepted transaction did not start");

   ast_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

FILE: design/kli_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_div: restoring divider, one quotient bit per cycle
// Unsigned 64-bit dividend by 33-bit divisor, 64 iterations.
// ----------------------------------------------------------------------------
module kli_div (
   input  logic                  clock,
   input  logic                  reset,
   input  kli_pkg::div_cmd_type  cmd,
   output kli_pkg::div_stat_type stat
);

   logic [63:0] quo_ff, quo_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic [34:0] diff;

   always_comb begin
      trial = {rem_ff[32:0], quo_ff[63]};
      diff  = {1'b0, trial} - {2'b00, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[34]) begin
            rem_in = diff[33:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy      = busy_ff;
   assign stat.done      = done_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff[32:0];

endmodule

FILE: design/kli_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kli_mem: keyframe store
// One write port, one registered read port; valid bits give the zero reset.
// ----------------------------------------------------------------------------
module kli_mem #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [kli_pkg::PHASE_W-1:0]   wr_phase,
   input  logic [kli_pkg::VALUE_W-1:0]   wr_value,
   input  logic [AW-1:0]                 rd_addr,
   output logic [kli_pkg::PHASE_W-1:0]   rd_phase,
   output logic [kli_pkg::VALUE_W-1:0]   rd_value
);

   logic [kli_pkg::PHASE_W+kli_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [kli_pkg::PHASE_W+kli_pkg::VALUE_W-1:0] rd_ff;
   logic             rv_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= {wr_phase, wr_value};
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         if (wr_en) vld_ff[wr_addr] <= 1'b1;
         rv_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_phase = rv_ff ? rd_ff[kli_pkg::PHASE_W+kli_pkg::VALUE_W-1:kli_pkg::VALUE_W] : '0;
   assign rd_value = rv_ff ? rd_ff[kli_pkg::VALUE_W-1:0] : '0;

endmodule

FILE: tb/tb_keyframe_linear_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_linear_interpolator_top: self-checking keyframe interpolator bench
// Drives keyframe writes and time queries over the req stream, programs the
// animation registers over APB between phases, and compares every rsp
// transaction against a local fixed-point interpolation model or typed
// results; a short directed table leads, then random key sets and queries.
// ----------------------------------------------------------------------------
module tb_keyframe_linear_interpolator_top;

   localparam int unsigned NUM_KEYS  = 16;
   localparam int unsigned WDOG_MAX  = 5000;
   localparam int unsigned HOLD_LEN  = 1500;
   localparam int unsigned ITEM_GOAL = 1950;

   typedef struct {
      logic        ok;
      logic [31:0] value;
      logic        at_end;
   } kf_result_type;

   typedef struct {
      bit            is_cfg;
      logic [1:0]    reg_idx;
      logic [31:0]   reg_val;
      logic          func;
      logic [3:0]    idx;
      logic [16:0]   ph;
      logic [31:0]   val;
      logic [31:0]   t;
      bit            typed;
      kf_result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   keyframe_linear_interpolator_top #(.MAX_KEYS(NUM_KEYS)) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [31:0] m_start;
   logic [31:0] m_run;
   logic        m_loop;
   logic [4:0]  m_count;
   logic [16:0] m_phase [NUM_KEYS];
   logic [31:0] m_value [NUM_KEYS];

   kf_result_type expected_q[$];
   stim_row_type  sent_q[$];
   int          errors = 0;
   int          quiet_cycles = 0;
   int          n_items = 0, n_writes = 0, n_queries = 0, n_ends = 0, n_cfg = 0;
   bit          hold_rsp = 1'b0;
   bit          burst_mode = 1'b0;

   function automatic logic [16:0] time_to_phase(logic [31:0] t);
      logic [63:0] d;
      if (m_run == 0) return 17'(kli_pkg::ONE_Q16);
      if (t > m_start) begin
         d = 64'((t - m_start) % m_run);
         return 17'((d * kli_pkg::ONE_Q16) / m_run);
      end
      d = 64'((m_start - t) % m_run);
      return 17'(kli_pkg::ONE_Q16 - ((d * kli_pkg::ONE_Q16) / m_run));
   endfunction

   function automatic logic [31:0] lerp_keys(logic [16:0] ph, int n);
      int b;
      longint dv, dt, off;
      b = 0;
      if (ph < m_phase[0]) return m_value[0];
      for (int i = 0; i < n; i++) begin
         if (m_phase[i] <= ph) b = i;
         else break;
      end
      if (b + 1 >= n) return m_value[n-1];
      dv  = longint'($signed(m_value[b+1])) - longint'($signed(m_value[b]));
      dt  = longint'(m_phase[b+1]) - longint'(m_phase[b]);
      off = longint'(ph) - longint'(m_phase[b]);
      return 32'(longint'($signed(m_value[b])) + (dv * off) / dt);
   endfunction

   // applies one transaction to the model and returns the expected rsp
   function automatic kf_result_type predict_keyframe_result(stim_row_type r);
      kf_result_type res;
      int n;
      logic [31:0] end_t;
      res = '{1'b0, 32'd0, 1'b0};
      n = (m_count > NUM_KEYS) ? NUM_KEYS : int'(m_count);
      end_t = m_start + m_run;
      if (r.func == kli_pkg::FN_WRITE) begin
         if (int'(r.idx) < n) begin
            m_phase[r.idx] = r.ph;
            m_value[r.idx] = r.val;
            res.ok = 1'b1;
         end
      end else if (n > 0) begin
         res.ok = 1'b1;
         if (!m_loop && r.t < m_start) begin
            res.value = m_value[0];
            res.at_end = 1'b1;
         end else if (!m_loop && r.t > end_t) begin
            res.value = m_value[n-1];
            res.at_end = 1'b1;
         end else begin
            res.value = lerp_keys(time_to_phase(r.t), n);
         end
      end
      return res;
   endfunction

   // monitors on the rising edge
   always @(posedge clock) begin
      stim_row_type  r;
      kf_result_type want, got;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else if (req_tvalid || expected_q.size() > 0) quiet_cycles <= quiet_cycles + 1;
         if (req_tvalid && req_tready) begin
            r = sent_q.pop_front();
            want = predict_keyframe_result(r);
            expected_q.push_back(r.typed ? r.want : want);
            if (r.func == kli_pkg::FN_WRITE) n_writes++;
            else n_queries++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.ok = rsp_tdata[0];
            got.value = rsp_tdata[32:1];
            got.at_end = rsp_tdata[33];
            if (expected_q.size() == 0) begin
               $error("rsp transaction with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (got.at_end) n_ends++;
               if (got.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, got.ok);
                  errors++;
               end
               if (got.value !== want.value) begin
                  $error("result_value: expected %h, got %h", want.value, got.value);
                  errors++;
               end
               if (got.at_end !== want.at_end) begin
                  $error("at_end: expected %0d, got %0d", want.at_end, got.at_end);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WDOG_MAX) begin
         $display("watchdog: no transaction for %0d cycles", WDOG_MAX);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (burst_mode || p < 60) return 0;
      if (p < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // receiver side
   initial begin
      int g;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
            hold_rsp = 1'b0;
         end
         g = pick_gap();
         if (g == 0) begin
            rsp_tready = 1'b1;
            @(negedge clock);
         end else begin
            rsp_tready = 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(stim_row_type r);
      int g;
      sent_q.push_back(r);
      req_tdata = {2'b00, r.t, r.val, r.ph, r.idx, r.func};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      n_items++;
      g = pick_gap();
      if (g > 0) begin
         req_tvalid = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (expected_q.size() > 0 || sent_q.size() > 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] ri, logic [31:0] v);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {ri, 2'b00};
      csr_pwdata = v;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (ri)
         kli_pkg::REG_START: m_start = v;
         kli_pkg::REG_RUN:   m_run = v;
         kli_pkg::REG_LOOP:  m_loop = v[0];
         kli_pkg::REG_COUNT: m_count = v[4:0];
         default: ;
      endcase
      n_cfg++;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   function automatic stim_row_type cfg_row(logic [1:0] ri, logic [31:0] v);
      stim_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.reg_idx = ri;
      r.reg_val = v;
      return r;
   endfunction

   function automatic stim_row_type item_row(logic fn, logic [3:0] idx, logic [16:0] ph,
                                             logic [31:0] val, logic [31:0] t);
      stim_row_type r;
      r = '{default: '0};
      r.func = fn;
      r.idx = idx;
      r.ph = ph;
      r.val = val;
      r.t = t;
      return r;
   endfunction

   function automatic stim_row_type typed_row(stim_row_type r, logic ok, logic [31:0] v,
                                              logic e);
      r.typed = 1'b1;
      r.want = '{ok, v, e};
      return r;
   endfunction

   function automatic logic [31:0] pick_time();
      int p;
      p = $urandom_range(0, 99);
      if (p < 30) return m_start + ((m_run == 0) ? 32'd0 : $urandom_range(0, 32'(m_run)));
      if (p < 45) return m_start + 32'($urandom_range(0, 6)) - 32'd3;
      if (p < 60) return m_start + m_run + 32'($urandom_range(0, 6)) - 32'd3;
      if (p < 70) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      return $urandom();
   endfunction

   stim_row_type table_q[$];

   initial begin
      int n, p, nq, step;
      logic [16:0] ph;
      logic [31:0] v;
      stim_row_type r;
      m_start = 0; m_run = 0; m_loop = 1'b1; m_count = 0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         m_phase[i] = '0;
         m_value[i] = '0;
      end

      // directed table
      table_q.push_back(typed_row(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 0), 0, 0, 0));
      table_q.push_back(typed_row(item_row(kli_pkg::FN_WRITE, 0, 17'h100, 32'h1, 0),
                                  0, 0, 0));
      table_q.push_back(cfg_row(kli_pkg::REG_COUNT, 32'd31));
      table_q.push_back(cfg_row(kli_pkg::REG_START, 32'h100));
      table_q.push_back(cfg_row(kli_pkg::REG_RUN, 32'h1000));
      table_q.push_back(cfg_row(kli_pkg::REG_LOOP, 32'd0));
      table_q.push_back(typed_row(item_row(kli_pkg::FN_WRITE, 0, 0, 32'h8000_0000, 0),
                                  1, 0, 0));
      table_q.push_back(typed_row(item_row(kli_pkg::FN_WRITE, 15, 17'(kli_pkg::ONE_Q16),
                                           32'h7FFF_FFFF, 0), 1, 0, 0));
      table_q.push_back(item_row(kli_pkg::FN_WRITE, 1, 17'h08000, 32'h0001_0000, 0));
      table_q.push_back(typed_row(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 32'd0),
                                  1, 32'h8000_0000, 1));
      table_q.push_back(typed_row(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 32'hFFFF_FFFF),
                                  1, 32'h7FFF_FFFF, 1));
      table_q.push_back(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 32'h100));
      table_q.push_back(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 32'h500));
      table_q.push_back(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 32'h1100));
      table_q.push_back(cfg_row(kli_pkg::REG_LOOP, 32'd1));
      table_q.push_back(cfg_row(kli_pkg::REG_RUN, 32'd0));
      table_q.push_back(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 32'd5));
      table_q.push_back(cfg_row(kli_pkg::REG_COUNT, 32'd2));
      table_q.push_back(cfg_row(kli_pkg::REG_RUN, 32'hFFFF_FFFF));
      table_q.push_back(cfg_row(kli_pkg::REG_START, 32'd0));
      table_q.push_back(typed_row(item_row(kli_pkg::FN_WRITE, 2, 0, 32'h5, 0), 0, 0, 0));
      // out-of-range phase pattern is stored as given
      table_q.push_back(item_row(kli_pkg::FN_WRITE, 1, 17'h1FFFF, 32'h7FFF_FFFF, 0));
      table_q.push_back(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 32'h7FFF_FFFF));
      table_q.push_back(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 32'd0));
      table_q.push_back(cfg_row(kli_pkg::REG_COUNT, 32'd1));
      table_q.push_back(typed_row(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 32'h1234_5678),
                                  1, 32'h8000_0000, 0));
      table_q.push_back(cfg_row(kli_pkg::REG_COUNT, 32'd0));
      table_q.push_back(typed_row(item_row(kli_pkg::FN_QUERY, 0, 0, 0, 32'h1), 0, 0, 0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (table_q[i]) begin
         if (table_q[i].is_cfg) begin
            wait_idle();
            csr_write(table_q[i].reg_idx, table_q[i].reg_val);
         end else begin
            send_item(table_q[i]);
         end
      end

      // random phases: program registers, load a key set, then query it
      for (int ph_no = 0; n_items < ITEM_GOAL; ph_no++) begin
         wait_idle();
         burst_mode = (ph_no % 5 == 3);
         p = $urandom_range(0, 9);
         csr_write(kli_pkg::REG_START, (p < 2) ? 32'd0 : (p < 4) ? 32'hFFFF_FFFF :
                              (p < 7) ? 32'($urandom_range(0, 20000)) : $urandom());
         p = $urandom_range(0, 9);
         csr_write(kli_pkg::REG_RUN, (p < 1) ? 32'd0 : (p < 2) ? 32'd1 :
                            (p < 3) ? 32'hFFFF_FFFF :
                            (p < 7) ? 32'($urandom_range(2, 5000)) : $urandom());
         csr_write(kli_pkg::REG_LOOP, 32'($urandom_range(0, 1)));
         p = $urandom_range(0, 19);
         csr_write(kli_pkg::REG_COUNT, (p < 1) ? 32'd0 : (p < 2) ? 32'd1 :
                              (p < 6) ? 32'd16 :
                              (p < 8) ? 32'($urandom_range(17, 31)) :
                              32'($urandom_range(2, 15)));
         n = (m_count > NUM_KEYS) ? NUM_KEYS : int'(m_count);
         ph = 17'($urandom_range(0, 4000));
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
               v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
               v = $urandom();
            send_item(item_row(kli_pkg::FN_WRITE, 4'(k), ph, v, $urandom()));
            if ($urandom_range(0, 9) == 0) begin
               ph = 17'($urandom());
            end else if (ph < kli_pkg::ONE_Q16) begin
               step = int'(ph) + int'($urandom_range(0, 2 * kli_pkg::ONE_Q16 / n));
               ph = 17'((step > int'(kli_pkg::ONE_Q16)) ? int'(kli_pkg::ONE_Q16) : step);
            end
         end
         if (ph_no == 3) hold_rsp = 1'b1;
         nq = $urandom_range(30, 70);
         for (int q = 0; q < nq; q++) begin
            p = $urandom_range(0, 99);
            if (p < 85) begin
               r = item_row(kli_pkg::FN_QUERY, 4'($urandom()), 17'($urandom()), $urandom(),
                            pick_time());
            end else begin
               r = item_row(kli_pkg::FN_WRITE, 4'($urandom()), 17'($urandom()), $urandom(),
                            $urandom());
            end
            send_item(r);
         end
      end

      wait_idle();
      $display("covered %0d writes, %0d queries (%0d at_end), %0d register writes",
               n_writes, n_queries, n_ends, n_cfg);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
